[rtl/core/utf8dv_pkg.sv]
// Shared types for the UTF-8 stream decoder and validator.
// Holds the queue entry layout and the queue flag group; no dependencies.
package utf8dv_pkg;

    // Width of the totals as they appear on the result ports.
    localparam int unsigned TOTAL_WIDTH = 32;
    localparam int unsigned CP_WIDTH    = 21;
    localparam int unsigned LEN_WIDTH   = 3;

    // One pending result item, as written by the front and read by the back.
    typedef struct packed {
        logic [CP_WIDTH-1:0]    code_point;
        logic [LEN_WIDTH-1:0]   char_bytes;
        logic                   char_done;
        logic                   status;
        logic [TOTAL_WIDTH-1:0] char_total;
        logic [TOTAL_WIDTH-1:0] byte_total;
        logic                   text_end;
    } t_result;

    // Fill flags of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

[rtl/core/utf8dv_front.sv]
// Front part: accepts bytes, validates strict UTF-8 and assembles codepoints.
// Writes one result item into the queue when one is due; uses utf8dv_pkg.
module utf8dv_front #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_text,
    output logic                 o_push,
    output utf8dv_pkg::t_result  o_result
);
    import utf8dv_pkg::*;

    // Continuation byte bounds, general and after the lead bytes E0, ED, F0 and F4.
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] E0_LO     = 8'hA0;
    localparam logic [7:0] ED_HI     = 8'h9F;
    localparam logic [7:0] F0_LO     = 8'h90;
    localparam logic [7:0] F4_HI     = 8'h8F;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    logic [CP_WIDTH-1:0]    r_partial, n_partial;
    logic [1:0]             r_need, n_need;
    logic [LEN_WIDTH-1:0]   r_seq, n_seq;
    logic [7:0]             r_lo, n_lo;
    logic [7:0]             r_hi, n_hi;
    logic                   r_expect, n_expect;
    logic [COUNT_WIDTH-1:0] r_chars, n_chars;
    logic [COUNT_WIDTH-1:0] r_bytes, n_bytes;
    logic                   r_err, n_err;

    logic                   ok;
    logic                   done;
    logic [CP_WIDTH-1:0]    cp;
    logic [LEN_WIDTH-1:0]   len;
    logic [7:0]             lo;
    logic [7:0]             hi;
    logic [CP_WIDTH-1:0]    shifted;
    logic [COUNT_WIDTH-1:0] chars_inc;
    logic [COUNT_WIDTH-1:0] bytes_inc;
    logic [TOTAL_WIDTH-1:0] chars_out;
    logic [TOTAL_WIDTH-1:0] bytes_out;
    logic [TOTAL_WIDTH-1:0] chars_now;
    logic [TOTAL_WIDTH-1:0] bytes_now;

    // Counters advanced by one, for a counted byte or a completed character.
    assign chars_inc = r_chars + CNT_ONE;
    assign bytes_inc = r_bytes + CNT_ONE;

    // Totals on the ports show the low bits of the counters, zero-extended when the counters are narrower.
    if (COUNT_WIDTH >= TOTAL_WIDTH) begin : g_trunc
        assign chars_out = chars_inc[TOTAL_WIDTH-1:0];
        assign bytes_out = bytes_inc[TOTAL_WIDTH-1:0];
        assign chars_now = r_chars[TOTAL_WIDTH-1:0];
        assign bytes_now = r_bytes[TOTAL_WIDTH-1:0];
    end else begin : g_ext
        assign chars_out = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, chars_inc};
        assign bytes_out = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, bytes_inc};
        assign chars_now = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, r_chars};
        assign bytes_now = {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, r_bytes};
    end

    assign lo      = r_expect ? r_lo : CONT_LO;
    assign hi      = r_expect ? r_hi : CONT_HI;
    assign shifted = {r_partial[CP_WIDTH-7:0], i_data_byte[5:0]};

    // Decode step for one accepted byte.
    always_comb begin
        n_partial = r_partial;
        n_need    = r_need;
        n_seq     = r_seq;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_expect  = r_expect;
        n_chars   = r_chars;
        n_bytes   = r_bytes;
        n_err     = r_err;
        ok        = 1'b1;
        done      = 1'b0;
        cp        = '0;
        len       = '0;
        o_push    = 1'b0;
        o_result  = '0;

        if (i_accept) begin
            if (r_err) begin
                // Bytes after an error are dropped until the final one.
                if (i_end_of_text) begin
                    o_push              = 1'b1;
                    o_result.status     = 1'b1;
                    o_result.text_end   = 1'b1;
                    o_result.char_total = chars_now;
                    o_result.byte_total = bytes_now;
                end
            end else begin
                if (r_need == 2'd0) begin
                    // Lead byte: set the sequence length and first continuation bounds.
                    n_expect = 1'b1;
                    case (i_data_byte) inside
                        [8'h00:8'h7F]: begin
                            cp       = {{(CP_WIDTH-8){1'b0}}, i_data_byte};
                            len      = 3'd1;
                            done     = 1'b1;
                            n_seq    = 3'd1;
                            n_expect = r_expect;
                        end
                        [8'hC2:8'hDF]: begin
                            n_partial = {{(CP_WIDTH-5){1'b0}}, i_data_byte[4:0]};
                            n_need = 2'd1; n_seq = 3'd2; n_lo = CONT_LO; n_hi = CONT_HI;
                        end
                        8'hE0: begin
                            n_partial = {{(CP_WIDTH-4){1'b0}}, i_data_byte[3:0]};
                            n_need = 2'd2; n_seq = 3'd3; n_lo = E0_LO; n_hi = CONT_HI;
                        end
                        8'hED: begin
                            n_partial = {{(CP_WIDTH-4){1'b0}}, i_data_byte[3:0]};
                            n_need = 2'd2; n_seq = 3'd3; n_lo = CONT_LO; n_hi = ED_HI;
                        end
                        [8'hE1:8'hEF]: begin
                            n_partial = {{(CP_WIDTH-4){1'b0}}, i_data_byte[3:0]};
                            n_need = 2'd2; n_seq = 3'd3; n_lo = CONT_LO; n_hi = CONT_HI;
                        end
                        8'hF0: begin
                            n_partial = {{(CP_WIDTH-3){1'b0}}, i_data_byte[2:0]};
                            n_need = 2'd3; n_seq = 3'd4; n_lo = F0_LO; n_hi = CONT_HI;
                        end
                        [8'hF1:8'hF3]: begin
                            n_partial = {{(CP_WIDTH-3){1'b0}}, i_data_byte[2:0]};
                            n_need = 2'd3; n_seq = 3'd4; n_lo = CONT_LO; n_hi = CONT_HI;
                        end
                        8'hF4: begin
                            n_partial = {{(CP_WIDTH-3){1'b0}}, i_data_byte[2:0]};
                            n_need = 2'd3; n_seq = 3'd4; n_lo = CONT_LO; n_hi = F4_HI;
                        end
                        default: begin
                            ok       = 1'b0;
                            n_expect = r_expect;
                        end
                    endcase
                end else if (i_data_byte < lo || i_data_byte > hi) begin
                    ok = 1'b0;
                end else begin
                    // Continuation byte: shift in six payload bits.
                    n_partial = shifted;
                    n_need    = r_need - 2'd1;
                    n_expect  = 1'b0;
                    if (r_need == 2'd1) begin
                        cp   = shifted;
                        len  = r_seq;
                        done = 1'b1;
                    end
                end

                if (ok) begin
                    n_bytes = bytes_inc;
                    if (done) begin
                        n_chars   = chars_inc;
                        n_partial = '0;
                    end
                end else begin
                    n_err     = 1'b1;
                    n_partial = '0;
                    n_need    = 2'd0;
                    n_expect  = 1'b0;
                end

                // A result is due for a completed codepoint, an error or the final byte.
                o_push              = i_end_of_text || done || !ok;
                o_result.code_point = done ? cp : '0;
                o_result.char_bytes = done ? len : '0;
                o_result.char_done  = done;
                o_result.status     = i_end_of_text ? (n_err || n_need != 2'd0) : !ok;
                o_result.char_total = done ? chars_out : chars_now;
                o_result.byte_total = ok ? bytes_out : bytes_now;
                o_result.text_end   = i_end_of_text;
            end

            // The final byte returns all per-text state to its reset values.
            if (i_end_of_text) begin
                n_partial = '0;
                n_need    = 2'd0;
                n_seq     = '0;
                n_lo      = CONT_LO;
                n_hi      = CONT_HI;
                n_expect  = 1'b0;
                n_chars   = '0;
                n_bytes   = '0;
                n_err     = 1'b0;
            end
        end
    end

    // Decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_need    <= 2'd0;
            r_seq     <= '0;
            r_lo      <= CONT_LO;
            r_hi      <= CONT_HI;
            r_expect  <= 1'b0;
            r_chars   <= '0;
            r_bytes   <= '0;
            r_err     <= 1'b0;
        end else begin
            r_partial <= n_partial;
            r_need    <= n_need;
            r_seq     <= n_seq;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_expect  <= n_expect;
            r_chars   <= n_chars;
            r_bytes   <= n_bytes;
            r_err     <= n_err;
        end
    end

endmodule

[rtl/core/utf8dv_queue.sv]
// Short queue of result items between the front and the back.
// Register array with read and write pointers; uses utf8dv_pkg.
module utf8dv_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  utf8dv_pkg::t_result  i_result,
    input  logic                 i_pop,
    output utf8dv_pkg::t_result  o_result,
    output utf8dv_pkg::t_q_flags o_flags
);
    import utf8dv_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_flags.full  = (r_cnt == CNT_FULL);
    assign o_flags.empty = (r_cnt == '0);
    assign do_push       = i_push && !o_flags.full;
    assign do_pop        = i_pop && !o_flags.empty;
    assign o_result      = r_mem[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_result;
        end
    end

endmodule

[rtl/core/utf8dv_back.sv]
// Back part: takes result items from the queue, classifies the codepoint
// and holds the item in the output register; uses utf8dv_pkg.
module utf8dv_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  utf8dv_pkg::t_result  i_result,
    input  utf8dv_pkg::t_q_flags i_flags,
    input  logic                 i_stall,
    output logic                 o_pop,
    output logic                 o_valid,
    output utf8dv_pkg::t_result  o_result,
    output logic                 o_is_control,
    output logic                 o_is_space
);
    import utf8dv_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;
    logic    r_ctrl;
    logic    r_space;
    logic    ctrl;
    logic    space;
    logic    load;

    // Control and whitespace classes of a completed codepoint.
    always_comb begin
        ctrl  = 1'b0;
        space = 1'b0;
        if (i_result.char_done) begin
            ctrl = (i_result.code_point <= 21'h1F) || (i_result.code_point == 21'h7F) ||
                   (i_result.code_point >= 21'h80 && i_result.code_point <= 21'h9F);
            space = (i_result.code_point >= 21'h09 && i_result.code_point <= 21'h0D) ||
                    (i_result.code_point >= 21'h2000 && i_result.code_point <= 21'h200A) ||
                    (i_result.code_point == 21'h20) || (i_result.code_point == 21'h85) ||
                    (i_result.code_point == 21'hA0) || (i_result.code_point == 21'h1680) ||
                    (i_result.code_point == 21'h2028) || (i_result.code_point == 21'h2029) ||
                    (i_result.code_point == 21'h202F) || (i_result.code_point == 21'h205F) ||
                    (i_result.code_point == 21'h3000);
        end
    end

    // The output register refills whenever the queue holds an item and the register is empty or being taken.
    assign load    = !i_flags.empty && (!r_valid || !i_stall);
    assign o_pop   = load;
    assign n_valid = load ? 1'b1 : (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_result;
            r_ctrl   <= ctrl;
            r_space  <= space;
        end
    end

    assign o_valid      = r_valid;
    assign o_result     = r_result;
    assign o_is_control = r_ctrl;
    assign o_is_space   = r_space;

endmodule

[rtl/core/utf8_stream_decoder_validator_unit.sv]
// Top level of the strict UTF-8 stream decoder and validator.
// Instantiates utf8dv_front, utf8dv_queue and utf8dv_back; uses utf8dv_pkg.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   i_data_byte, i_end_of_text
//   output   out        o_valid / i_stall   o_code_point .. o_text_end
//
// One byte is taken every cycle while o_stall is low; the front decodes it in that
// cycle and its result, if any, is written into the result queue and enters the
// output register from there when the output register is free.
// The front decode step is the only loop carried from byte to byte.
// o_stall rises only when the result queue (QUEUE_DEPTH items) is full.
// Reset is synchronous and active low and empties the queue and output.
module utf8_stream_decoder_validator_unit #(
    parameter int unsigned COUNT_WIDTH = 32,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_char_bytes,
    output logic        o_char_done,
    output logic        o_is_control,
    output logic        o_is_space,
    output logic        o_status,
    output logic [31:0] o_char_total,
    output logic [31:0] o_byte_total,
    output logic        o_text_end
);
    import utf8dv_pkg::*;

    logic     accept;
    logic     push;
    logic     pop;
    t_result  front_res;
    t_result  queue_res;
    t_result  out_res;
    t_q_flags q_flags;

    // The input side stalls only on a full queue.
    assign o_stall = q_flags.full;
    assign accept  = i_valid && !q_flags.full;

    utf8dv_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_result      (front_res)
    );

    utf8dv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (front_res),
        .i_pop    (pop),
        .o_result (queue_res),
        .o_flags  (q_flags)
    );

    utf8dv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (queue_res),
        .i_flags      (q_flags),
        .i_stall      (i_stall),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_result     (out_res),
        .o_is_control (o_is_control),
        .o_is_space   (o_is_space)
    );

    assign o_code_point = out_res.code_point;
    assign o_char_bytes = out_res.char_bytes;
    assign o_char_done  = out_res.char_done;
    assign o_status     = out_res.status;
    assign o_char_total = out_res.char_total;
    assign o_byte_total = out_res.byte_total;
    assign o_text_end   = out_res.text_end;

`ifndef ASSERT_OFF
    // The front never writes a result into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_flags.full |-> !push)
        else $error("result written into a full queue");

    // A completed codepoint never comes with an invalid status.
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_done) |-> (!o_status && o_char_bytes != 3'd0))
        else $error("completed codepoint with bad status or no length");

    // A one-byte character is always ASCII.
    a_ascii_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_done && o_char_bytes == 3'd1) |-> (o_code_point <= 21'h7F))
        else $error("one-byte character above the ASCII range");
`endif

endmodule
